>>> design/seqnum_ordered_reorder_buffer_unit_defines.svh
// Assertion macros for the sequence-ordered reorder buffer checker.
// Needs clk and arst_n in the scope where the macros are used.
`ifndef SEQNUM_ORDERED_REORDER_BUFFER_UNIT_DEFINES_SVH
`define SEQNUM_ORDERED_REORDER_BUFFER_UNIT_DEFINES_SVH

// Generic clocked property, off while reset is asserted.
`define SORB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sorb_checker: property violated");

// Same-cycle implication.
`define SORB_IMPLIES(lbl, ante, cons) \
	`SORB_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> design/sorb_pkg.sv
// Shared types, codes and the wrap-aware ordering function for the reorder buffer.
// No dependencies.
`timescale 1ns / 1ps

package sorb_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int SEQ_W     = 8;
	localparam int HANDLE_W  = 8;

	// Wrap window of the 8-bit sequence space
	localparam logic [SEQ_W-1:0] WRAP_HI = 8'd200;
	localparam logic [SEQ_W-1:0] WRAP_LO = 8'd100;

	typedef enum logic [1:0] {
		K_INSERT = 2'd0,
		K_REMOVE = 2'd1,
		K_DROP   = 2'd2,
		K_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL,
		OP_DROP
	} cell_op_t;

	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		cell_op_t            op;
		logic [SEQ_W-1:0]    seq;
		logic [HANDLE_W-1:0] handle;
	} cmd_t;

	// s goes before r
	function automatic logic orders_before(input logic [SEQ_W-1:0] s,
		input logic [SEQ_W-1:0] r);
		return (s < r) && !((r > WRAP_HI) && (s < WRAP_LO));
	endfunction

endpackage

>>> design/seqnum_ordered_reorder_buffer_unit.sv
// Top level of the sequence-ordered reorder buffer: control FSM, result register
// and the chain of sorb_cell slots. Depends on sorb_pkg and sorb_cell.
`timescale 1ns / 1ps

// Holds up to DEPTH (seq, handle) entries in wrap-aware order in a row of cells,
// front at cell 0. Every cell compares its entry with the operation in parallel
// and loads from itself, a neighbor or the new entry. Insert, remove
// and lookup are captured, then finish with at most one chain update. Drop
// shifts the whole chain left by one entry per cycle. A new operation is taken
// while the last result still waits on res_ready; the next result is held back
// until that slot frees.

module seqnum_ordered_reorder_buffer_unit #(
	parameter int DEPTH = sorb_pkg::DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            op_valid,
	output logic                            op_ready,
	input  logic [1:0]                      kind,
	input  logic [sorb_pkg::SEQ_W-1:0]      seq,
	input  logic [sorb_pkg::HANDLE_W-1:0]   handle,
	output logic                            res_valid,
	input  logic                            res_ready,
	output logic [1:0]                      status,
	output logic [sorb_pkg::HANDLE_W-1:0]   found_handle,
	output logic [CW-1:0]                   dropped,
	output logic [CW-1:0]                   occupancy
);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                          state_q;
	sorb_pkg::kind_t                 kind_q;
	logic [sorb_pkg::SEQ_W-1:0]      seq_q;
	logic [sorb_pkg::HANDLE_W-1:0]   handle_q;
	logic [CW-1:0]                   count_q;
	logic [CW-1:0]                   drop_q;
	logic                            res_valid_q;
	sorb_pkg::status_t               status_q;
	logic [sorb_pkg::HANDLE_W-1:0]   found_handle_q;
	logic [CW-1:0]                   dropped_q;
	logic [CW-1:0]                   occupancy_q;

	sorb_pkg::cmd_t                  cmd;
	sorb_pkg::entry_t                ents [DEPTH];
	logic [DEPTH-1:0]                occ;
	logic [DEPTH-1:0]                sfx;
	logic [DEPTH-1:0]                pfx;
	logic [DEPTH-1:0]                first;
	sorb_pkg::entry_t                new_ent;

	logic                            slot_free;
	logic                            fin;
	logic [CW-1:0]                   count_d;
	logic [CW-1:0]                   drop_d;
	sorb_pkg::status_t               st_d;
	logic [sorb_pkg::HANDLE_W-1:0]   fh_d;
	logic [sorb_pkg::HANDLE_W-1:0]   hit_handle;
	logic                            found;

	assign new_ent.seq    = seq_q;
	assign new_ent.handle = handle_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sorb_pkg::entry_t l_ent;
		sorb_pkg::entry_t r_ent;
		logic             s_in;
		logic             s_left;
		logic             p_in;

		assign occ[i] = CW'(i) < count_q;

		if (i == 0) begin : g_head
			assign l_ent  = new_ent;
			assign s_left = 1'b1;
			assign p_in   = 1'b0;
		end else begin : g_body
			assign l_ent  = ents[i-1];
			assign s_left = sfx[i-1];
			assign p_in   = pfx[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_ent = ents[i];
			assign s_in  = 1'b0;
		end else begin : g_mid
			assign r_ent = ents[i+1];
			assign s_in  = sfx[i+1];
		end

		sorb_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occ      (occ[i]),
			.left     (l_ent),
			.right    (r_ent),
			.sfx_in   (s_in),
			.sfx_left (s_left),
			.pfx_in   (p_in),
			.ent      (ents[i]),
			.sfx_out  (sfx[i]),
			.pfx_out  (pfx[i]),
			.first    (first[i])
		);
	end

	// first[] is one-hot or zero
	always_comb begin
		hit_handle = '0;
		for (int i = 0; i < DEPTH; i++)
			hit_handle = hit_handle | (first[i] ? ents[i].handle : '0);
	end

	assign found     = |first;
	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		cmd.op     = sorb_pkg::OP_HOLD;
		cmd.seq    = seq_q;
		cmd.handle = handle_q;
		fin        = 1'b0;
		count_d    = count_q;
		drop_d     = drop_q;
		st_d       = sorb_pkg::ST_OK;
		fh_d       = '0;
		if (state_q == S_EXEC) begin
			case (kind_q)
				sorb_pkg::K_INSERT: begin
					if (slot_free) begin
						fin = 1'b1;
						if (count_q == CW'(DEPTH)) begin
							st_d = sorb_pkg::ST_FULL;
						end else begin
							cmd.op  = sorb_pkg::OP_INS;
							count_d = count_q + 1'b1;
						end
					end
				end
				sorb_pkg::K_REMOVE, sorb_pkg::K_LOOKUP: begin
					if (slot_free) begin
						fin = 1'b1;
						if (found) begin
							fh_d = hit_handle;
							if (kind_q == sorb_pkg::K_REMOVE) begin
								cmd.op  = sorb_pkg::OP_DEL;
								count_d = count_q - 1'b1;
							end
						end else begin
							st_d = sorb_pkg::ST_NOT_FOUND;
						end
					end
				end
				sorb_pkg::K_DROP: begin
					if ((count_q != '0) && !first[0]) begin
						cmd.op  = sorb_pkg::OP_DROP;
						count_d = count_q - 1'b1;
						drop_d  = drop_q + 1'b1;
					end else if (slot_free) begin
						fin = 1'b1;
					end
				end
				default: fin = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			drop_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fin)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						kind_q   <= sorb_pkg::kind_t'(kind);
						seq_q    <= seq;
						handle_q <= handle;
						drop_q   <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					count_q <= count_d;
					drop_q  <= drop_d;
					if (fin) begin
						state_q        <= S_IDLE;
						status_q       <= st_d;
						found_handle_q <= fh_d;
						dropped_q      <= drop_d;
						occupancy_q    <= count_d;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign op_ready     = (state_q == S_IDLE);
	assign res_valid    = res_valid_q;
	assign status       = status_q;
	assign found_handle = found_handle_q;
	assign dropped      = dropped_q;
	assign occupancy    = occupancy_q;

endmodule

>>> design/sorb_cell.sv
// One slot of the reorder chain: holds an entry, compares it to the command and
// shifts from its left or right neighbor. Depends on sorb_pkg.
`timescale 1ns / 1ps

module sorb_cell (
	input  logic            clk,
	input  sorb_pkg::cmd_t  cmd,
	input  logic            occ,
	input  sorb_pkg::entry_t left,
	input  sorb_pkg::entry_t right,
	input  logic            sfx_in,
	input  logic            sfx_left,
	input  logic            pfx_in,
	output sorb_pkg::entry_t ent,
	output logic            sfx_out,
	output logic            pfx_out,
	output logic            first
);

	sorb_pkg::entry_t ent_q;
	sorb_pkg::entry_t ent_d;
	logic             ge;
	logic             match;
	logic             take_new;

	// ge: new entry does not order before this one
	assign ge       = occ && !sorb_pkg::orders_before(cmd.seq, ent_q.seq);
	assign match    = occ && (ent_q.seq == cmd.seq);
	assign sfx_out  = sfx_in | ge;
	assign pfx_out  = pfx_in | match;
	assign first    = match && !pfx_in;
	assign take_new = sfx_left && !sfx_out;
	assign ent      = ent_q;

	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			sorb_pkg::OP_INS: begin
				if (take_new) begin
					ent_d.seq    = cmd.seq;
					ent_d.handle = cmd.handle;
				end else if (!sfx_left) begin
					ent_d = left;
				end
			end
			sorb_pkg::OP_DEL: begin
				if (pfx_out)
					ent_d = right;
			end
			sorb_pkg::OP_DROP: ent_d = right;
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

>>> design/sorb_checker.sv
// Port-level checker for the reorder buffer, bound to the top level.
// Depends on sorb_pkg and seqnum_ordered_reorder_buffer_unit_defines.svh.
`timescale 1ns / 1ps
`include "seqnum_ordered_reorder_buffer_unit_defines.svh"

module sorb_checker #(
	parameter int DEPTH = sorb_pkg::DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          op_valid,
	input logic                          op_ready,
	input logic [1:0]                    kind,
	input logic [sorb_pkg::SEQ_W-1:0]    seq,
	input logic [sorb_pkg::HANDLE_W-1:0] handle,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [1:0]                    status,
	input logic [sorb_pkg::HANDLE_W-1:0] found_handle,
	input logic [CW-1:0]                 dropped,
	input logic [CW-1:0]                 occupancy
);

	`SORB_IMPLIES(a_status_code, res_valid, status == sorb_pkg::ST_OK || status == sorb_pkg::ST_NOT_FOUND || status == sorb_pkg::ST_FULL)

	`SORB_IMPLIES(a_occ_bound, res_valid, occupancy <= CW'(DEPTH))

	`SORB_IMPLIES(a_full_occ, res_valid && status == sorb_pkg::ST_FULL, occupancy == CW'(DEPTH) && found_handle == '0 && dropped == '0)

	`SORB_IMPLIES(a_miss_zero, res_valid && status == sorb_pkg::ST_NOT_FOUND, found_handle == '0 && dropped == '0)

	`SORB_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(status) && $stable(found_handle) && $stable(occupancy))

endmodule

bind seqnum_ordered_reorder_buffer_unit sorb_checker #(.DEPTH(DEPTH)) u_sorb_checker (.*);

>>> verif/tb.sv
// Testbench for seqnum_ordered_reorder_buffer_unit: directed table, then random traffic,
// each result checked against a typed table row or an in-bench model of the wrap-ordered entry table.
// Depends on sorb_pkg and the design sources.
`timescale 1ns / 1ps

module tb;
	import sorb_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CW    = $clog2(DEPTH + 1);

	typedef struct packed {
		status_t        status;
		logic [7:0]     fh;
		logic [CW-1:0]  dropped;
		logic [CW-1:0]  occ;
	} rob_res_t;

	typedef struct {
		kind_t      kind;
		logic [7:0] seq;
		logic [7:0] handle;
		bit         typed;
		rob_res_t   exp;
	} stim_row_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          op_valid = 1'b0;
	logic          op_ready;
	logic [1:0]    kind = K_INSERT;
	logic [7:0]    seq = '0;
	logic [7:0]    handle = '0;
	logic          res_valid;
	logic          res_ready = 1'b0;
	logic [1:0]    status;
	logic [7:0]    found_handle;
	logic [CW-1:0] dropped;
	logic [CW-1:0] occupancy;

	seqnum_ordered_reorder_buffer_unit #(.DEPTH(DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.kind         (kind),
		.seq          (seq),
		.handle       (handle),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.status       (status),
		.found_handle (found_handle),
		.dropped      (dropped),
		.occupancy    (occupancy)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// model of the entry table, front at index 0
	logic [7:0] rob_seq [DEPTH];
	logic [7:0] rob_hdl [DEPTH];
	int         rob_cnt = 0;
	int         rob_peak = 0;

	rob_res_t   op_results_due [$];
	stim_row_t  dir_rows [$];

	int n_ops = 0;
	int n_results = 0;
	int n_full = 0;
	int n_drops = 0;
	int errors = 0;

	int press_req = 0;
	int press_seen = 0;
	bit rx_steady = 1'b0;

	function automatic bit wrap_before(logic [7:0] s, logic [7:0] r);
		return (s < r) && !(r > 8'd200 && s < 8'd100);
	endfunction

	function automatic void rob_pop(int p);
		for (int i = p; i + 1 < rob_cnt; i++) begin
			rob_seq[i] = rob_seq[i + 1];
			rob_hdl[i] = rob_hdl[i + 1];
		end
		rob_cnt--;
	endfunction

	function automatic rob_res_t rob_apply(kind_t k, logic [7:0] s, logic [7:0] h);
		rob_res_t r;
		int p;
		bit hit;
		r = '0;
		r.status = ST_OK;
		p = -1;
		hit = 1'b0;
		case (k)
			K_INSERT: begin
				if (rob_cnt >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					p = 0;
					for (int i = rob_cnt; i > 0; i--) begin
						if (!hit && !wrap_before(s, rob_seq[i - 1])) begin
							p = i;
							hit = 1'b1;
						end
					end
					for (int i = rob_cnt; i > p; i--) begin
						rob_seq[i] = rob_seq[i - 1];
						rob_hdl[i] = rob_hdl[i - 1];
					end
					rob_seq[p] = s;
					rob_hdl[p] = h;
					rob_cnt++;
				end
			end
			K_REMOVE, K_LOOKUP: begin
				for (int i = 0; i < rob_cnt; i++) begin
					if (p < 0 && rob_seq[i] == s)
						p = i;
				end
				if (p < 0) begin
					r.status = ST_NOT_FOUND;
				end else begin
					r.fh = rob_hdl[p];
					if (k == K_REMOVE)
						rob_pop(p);
				end
			end
			default: begin
				while (rob_cnt > 0 && rob_seq[0] != s) begin
					rob_pop(0);
					r.dropped++;
				end
			end
		endcase
		r.occ = CW'(rob_cnt);
		if (rob_cnt > rob_peak)
			rob_peak = rob_cnt;
		return r;
	endfunction

	function automatic stim_row_t mk_row(kind_t k, logic [7:0] s, logic [7:0] h,
		bit typed = 1'b0, status_t st = ST_OK, int fh = 0, int dr = 0, int oc = 0);
		stim_row_t row;
		row.kind = k;
		row.seq = s;
		row.handle = h;
		row.typed = typed;
		row.exp.status = st;
		row.exp.fh = 8'(fh);
		row.exp.dropped = CW'(dr);
		row.exp.occ = CW'(oc);
		return row;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one op transfer; must be entered at a rising edge
	task automatic xfer_op(input kind_t k, input logic [7:0] s, input logic [7:0] h,
		input bit typed, input rob_res_t exp, input int gap);
		rob_res_t pred;
		op_valid <= 1'b1;
		kind     <= k;
		seq      <= s;
		handle   <= h;
		do
			@(posedge clk);
		while (!op_ready);
		pred = rob_apply(k, s, h);
		op_results_due.push_back(typed ? exp : pred);
		n_ops++;
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: random backpressure, long hold-off on request, checking
	initial begin
		int run_left;
		int hold_left;
		bit run_hi;
		rob_res_t want;
		run_left = 0;
		hold_left = 0;
		run_hi = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				n_results++;
				if (op_results_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] result with nothing pending: st=%0d fh=%0d dr=%0d occ=%0d",
							$time, status, found_handle, dropped, occupancy);
				end else begin
					want = op_results_due.pop_front();
					if (want.status == ST_FULL)
						n_full++;
					if (status !== want.status || found_handle !== want.fh ||
						dropped !== want.dropped || occupancy !== want.occ) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] mismatch: exp st=%0d fh=%0d dr=%0d occ=%0d, got st=%0d fh=%0d dr=%0d occ=%0d",
								$time, want.status, want.fh, want.dropped, want.occ,
								status, found_handle, dropped, occupancy);
					end
				end
			end
			if (press_req != press_seen) begin
				press_seen = press_req;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (rx_steady) begin
				res_ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					if ($urandom_range(0, 99) < 60) begin
						run_hi = 1'b1;
						run_left = $urandom_range(1, 40);
					end else begin
						run_hi = 1'b0;
						run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
							: $urandom_range(1, 3);
					end
				end
				run_left--;
				res_ready <= run_hi;
			end
		end
	end

	initial begin
		#8_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		kind_t      rk;
		logic [7:0] rs;
		logic [7:0] rh;
		logic [7:0] win_base;
		int         pick;
		int         op;
		int         n_dir;
		bit         steady;
		stim_row_t  row;

		win_base = 8'd150;

		dir_rows.push_back(mk_row(K_LOOKUP, 8'd0,   8'h00, 1, ST_NOT_FOUND, 0, 0, 0));
		dir_rows.push_back(mk_row(K_REMOVE, 8'd255, 8'hFF, 1, ST_NOT_FOUND, 0, 0, 0));
		dir_rows.push_back(mk_row(K_DROP,   8'd7,   8'h00, 1, ST_OK, 0, 0, 0));
		dir_rows.push_back(mk_row(K_INSERT, 8'd100, 8'hFF, 1, ST_OK, 0, 0, 1));
		dir_rows.push_back(mk_row(K_INSERT, 8'd50,  8'h00));
		dir_rows.push_back(mk_row(K_INSERT, 8'd250, 8'hA5));
		dir_rows.push_back(mk_row(K_INSERT, 8'd5,   8'h5A));
		dir_rows.push_back(mk_row(K_INSERT, 8'd201, 8'h01));
		dir_rows.push_back(mk_row(K_INSERT, 8'd100, 8'h02));
		dir_rows.push_back(mk_row(K_INSERT, 8'd0,   8'h03));
		dir_rows.push_back(mk_row(K_INSERT, 8'd255, 8'h80));
		dir_rows.push_back(mk_row(K_LOOKUP, 8'd100, 8'hFF));
		dir_rows.push_back(mk_row(K_LOOKUP, 8'd77,  8'h00));
		dir_rows.push_back(mk_row(K_REMOVE, 8'd100, 8'h00));
		dir_rows.push_back(mk_row(K_LOOKUP, 8'd100, 8'h00));
		dir_rows.push_back(mk_row(K_REMOVE, 8'd3,   8'hFF));
		dir_rows.push_back(mk_row(K_DROP,   8'd5,   8'h00));
		dir_rows.push_back(mk_row(K_DROP,   8'd99,  8'hFF));
		dir_rows.push_back(mk_row(K_LOOKUP, 8'd5,   8'h00, 1, ST_NOT_FOUND, 0, 0, 0));
		dir_rows.push_back(mk_row(K_INSERT, 8'd0,   8'h00));
		dir_rows.push_back(mk_row(K_INSERT, 8'd255, 8'hFF));
		dir_rows.push_back(mk_row(K_DROP,   8'd0,   8'h00));
		dir_rows.push_back(mk_row(K_REMOVE, 8'd255, 8'h00));
		dir_rows.push_back(mk_row(K_REMOVE, 8'd0,   8'hFF, 1, ST_OK, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			xfer_op(row.kind, row.seq, row.handle, row.typed, row.exp, pick_gap(1'b0));
		end
		n_dir = n_ops;

		for (int rnd = 0; rnd < 10; rnd++) begin
			steady = (rnd % 4 == 1);
			rx_steady <= steady;
			if (rnd == 3 || rnd == 7) begin
				// fill past capacity; first time the result side holds off meanwhile
				if (rnd == 3)
					press_req <= press_req + 1;
				for (int n = 0; n < 40; n++) begin
					rs = win_base + 8'($urandom_range(0, 60));
					win_base += 8'($urandom_range(0, 3));
					xfer_op(K_INSERT, rs, 8'($urandom), 1'b0, '0,
						(rnd == 3) ? 0 : pick_gap(steady));
				end
			end
			for (int n = 0; n < 180; n++) begin
				pick = $urandom_range(0, 99);
				rh = 8'($urandom);
				if (pick < 8) begin
					rk = kind_t'($urandom_range(0, 3));
					rs = 8'($urandom);
				end else begin
					op = $urandom_range(0, 99);
					if (rob_cnt < 3)
						op = op / 2;
					if (op < 45) begin
						rk = K_INSERT;
						if (rob_cnt > 0 && $urandom_range(0, 9) == 0)
							rs = rob_seq[$urandom_range(0, rob_cnt - 1)];
						else
							rs = win_base + 8'($urandom_range(0, 60));
						win_base += 8'($urandom_range(0, 3));
					end else if (op < 85) begin
						rk = (op < 65) ? K_REMOVE : K_LOOKUP;
						if (rob_cnt > 0 && $urandom_range(0, 4) != 0)
							rs = rob_seq[$urandom_range(0, rob_cnt - 1)];
						else
							rs = 8'($urandom);
					end else begin
						rk = K_DROP;
						n_drops++;
						if (rob_cnt > 0 && $urandom_range(0, 9) < 8)
							rs = rob_seq[$urandom_range(0, (rob_cnt > 4) ? 4 : rob_cnt - 1)];
						else
							rs = 8'($urandom);
					end
				end
				xfer_op(rk, rs, rh, 1'b0, '0, pick_gap(steady));
			end
		end

		op_valid <= 1'b0;
		rx_steady <= 1'b0;
		while (op_results_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Ran %0d buffer ops (%0d from the directed table, %0d random drops), %0d results",
			n_ops, n_dir, n_drops, n_results);
		$display("checked, %0d table-full rejects, peak occupancy %0d, %0d mismatches",
			n_full, rob_peak, errors);
		if (errors == 0 && op_results_due.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/sorb_pkg.sv
design/sorb_cell.sv
design/seqnum_ordered_reorder_buffer_unit.sv
design/sorb_checker.sv
verif/tb.sv
